// ===== sv/ftle_pkg.sv =====
// Shared constants and types for the FTLE core.
`timescale 1ns / 1ps
package ftle_pkg;
	localparam int FRAC_BITS  = 24;
	localparam int POS_W      = 40;
	localparam int SPAN_W     = 39;
	localparam int HOR_W      = 12;
	localparam int JAC_FRAC   = 20;
	localparam int JAC_W      = 31;          // magnitude of a Jacobian entry
	localparam int NUM_W      = POS_W + 1 + JAC_FRAC;   // scaled magnitude of a difference
	localparam int SQ_W       = 64;
	localparam int ROOT_W     = 32;
	localparam int S2_W       = 33;
	localparam int L2_W       = 40;          // signed log2 in Q.32
	localparam int LN_W       = 40;
	localparam int QUO_W      = 40;
	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
	localparam logic [JAC_W-1:0] JAC_MAX = {JAC_W{1'b1}} >> 1;

	localparam logic [1:0] ST_NORMAL   = 2'd0;
	localparam logic [1:0] ST_ZERO_HOR = 2'd1;
	localparam logic [1:0] ST_ZERO_STR = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [HOR_W-1:0]  hor;
	} ctl_t;
endpackage

// ===== sv/ftle_from_neighbor_spread_core.sv =====
// FTLE core: Jacobian, Cauchy-Green stretch, logarithm and per-day rate pipeline.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  in      | east/north/west/south lon/lat, spans,   | start & !busy
//          | horizon_days                            |
//  out     | lyapunov_rate, status                   | done, one cycle, no stall
//
// One item enters per cycle; busy is held low. done rises once the accepted item has
// passed through 61 Jacobian divide stages (one quotient bit each), 32 square root
// stages (one root bit each), 32 log squaring stages (one fraction bit each),
// 40 rate divide stages and 11 single register stages around them.
// Reset clears all valid bits; payload is not reset.
// The receiver cannot stall, so no stage ever holds.
`timescale 1ns / 1ps
module ftle_from_neighbor_spread_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [39:0]  east_lon,
	input  logic signed [39:0]  east_lat,
	input  logic signed [39:0]  north_lon,
	input  logic signed [39:0]  north_lat,
	input  logic signed [39:0]  west_lon,
	input  logic signed [39:0]  west_lat,
	input  logic signed [39:0]  south_lon,
	input  logic signed [39:0]  south_lat,
	input  logic        [38:0]  span_lon,
	input  logic        [38:0]  span_lat,
	input  logic        [11:0]  horizon_days,
	output logic                done,
	output logic signed [31:0]  lyapunov_rate,
	output logic        [1:0]   status
);
	localparam int NUM_W  = ftle_pkg::NUM_W;
	localparam int SPAN_W = ftle_pkg::SPAN_W;
	localparam int JAC_W  = ftle_pkg::JAC_W;
	localparam int HOR_W  = ftle_pkg::HOR_W;
	localparam int DQ     = NUM_W;           // quotient bits of the Jacobian divide
	localparam int RB     = 32;              // root bits
	localparam int FB     = 32;              // log fraction bits
	localparam int SH     = 32 - ftle_pkg::FRAC_BITS;
	localparam int DV_W   = HOR_W + SH;
	localparam int LN_W   = ftle_pkg::LN_W;
	localparam int RQ     = LN_W;            // quotient bits of the rate divide

	assign busy = 1'b0;

	// ---------------- stage 1: differences, magnitudes, spans
	logic              v_s1;
	logic [HOR_W-1:0]  hor_s1;
	logic [3:0]        neg_s1;
	logic [NUM_W-1:0]  num_s1 [4];
	logic [SPAN_W-1:0] spn_s1 [4];

	function automatic logic [40:0] mag41(input logic signed [40:0] x);
		mag41 = x[40] ? 41'(-x) : 41'(x);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		logic signed [40:0] df [4];
		logic [SPAN_W-1:0] sl, sa;
		df[0] = 41'(east_lon) - 41'(west_lon);
		df[1] = 41'(north_lon) - 41'(south_lon);
		df[2] = 41'(east_lat) - 41'(west_lat);
		df[3] = 41'(north_lat) - 41'(south_lat);
		sl = (span_lon == '0) ? SPAN_W'(1) : span_lon;
		sa = (span_lat == '0) ? SPAN_W'(1) : span_lat;
		hor_s1 <= horizon_days;
		for (int k = 0; k < 4; k++) begin
			neg_s1[k] <= df[k][40];
			// add half the span for round half up before dividing
			num_s1[k] <= NUM_W'({mag41(df[k]), {ftle_pkg::JAC_FRAC{1'b0}}})
				+ NUM_W'((k == 0 || k == 2) ? (sl >> 1) : (sa >> 1));
			spn_s1[k] <= (k == 0 || k == 2) ? sl : sa;
		end
	end

	// ---------------- divide pipeline: one quotient bit a stage
	logic              dv_v   [DQ+1];
	logic [HOR_W-1:0]  dv_h   [DQ+1];
	logic [3:0]        dv_n   [DQ+1];
	logic [NUM_W-1:0]  dv_rem [DQ+1][4];
	logic [NUM_W-1:0]  dv_num [DQ+1][4];
	logic [SPAN_W-1:0] dv_spn [DQ+1][4];
	logic [NUM_W-1:0]  dv_quo [DQ+1][4];

	always_comb begin
		dv_v[0] = v_s1;
		dv_h[0] = hor_s1;
		dv_n[0] = neg_s1;
		for (int k = 0; k < 4; k++) begin
			dv_rem[0][k] = '0;
			dv_num[0][k] = num_s1[k];
			dv_spn[0][k] = spn_s1[k];
			dv_quo[0][k] = '0;
		end
	end

	for (genvar i = 0; i < DQ; i++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[i+1] <= 1'b0;
			else dv_v[i+1] <= dv_v[i];
		end
		always_ff @(posedge clk) begin
			logic [NUM_W:0] r;
			dv_h[i+1] <= dv_h[i];
			dv_n[i+1] <= dv_n[i];
			for (int k = 0; k < 4; k++) begin
				r = {dv_rem[i][k], dv_num[i][k][NUM_W-1]};
				if (r >= (NUM_W+1)'(dv_spn[i][k])) begin
					dv_rem[i+1][k] <= NUM_W'(r - (NUM_W+1)'(dv_spn[i][k]));
					dv_quo[i+1][k] <= {dv_quo[i][k][NUM_W-2:0], 1'b1};
				end else begin
					dv_rem[i+1][k] <= NUM_W'(r);
					dv_quo[i+1][k] <= {dv_quo[i][k][NUM_W-2:0], 1'b0};
				end
				dv_num[i+1][k] <= dv_num[i][k] << 1;
				dv_spn[i+1][k] <= dv_spn[i][k];
			end
		end
	end

	// ---------------- stage J: saturate and sign
	logic              v_sj;
	logic [HOR_W-1:0]  hor_sj;
	logic signed [31:0] ja_sj, jb_sj, jc_sj, jd_sj;

	function automatic logic signed [31:0] jsat(input logic [NUM_W-1:0] q, input logic n);
		logic [JAC_W-1:0] m;
		m = (q > NUM_W'(ftle_pkg::JAC_MAX)) ? ftle_pkg::JAC_MAX : JAC_W'(q);
		jsat = n ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sj <= 1'b0;
		else v_sj <= dv_v[DQ];
	end
	always_ff @(posedge clk) begin
		hor_sj <= dv_h[DQ];
		ja_sj  <= jsat(dv_quo[DQ][0], dv_n[DQ][0]);
		jb_sj  <= jsat(dv_quo[DQ][1], dv_n[DQ][1]);
		jc_sj  <= jsat(dv_quo[DQ][2], dv_n[DQ][2]);
		jd_sj  <= jsat(dv_quo[DQ][3], dv_n[DQ][3]);
	end

	// ---------------- stage M: magnitudes of the four combinations
	logic              v_sm;
	logic [HOR_W-1:0]  hor_sm;
	logic [31:0]       cm_sm [4];

	function automatic logic [31:0] mag33(input logic signed [32:0] x);
		mag33 = x[32] ? 32'(-x) : 32'(x);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else v_sm <= v_sj;
	end
	always_ff @(posedge clk) begin
		hor_sm   <= hor_sj;
		cm_sm[0] <= mag33(33'(ja_sj) + 33'(jd_sj));
		cm_sm[1] <= mag33(33'(jc_sj) - 33'(jb_sj));
		cm_sm[2] <= mag33(33'(ja_sj) - 33'(jd_sj));
		cm_sm[3] <= mag33(33'(jc_sj) + 33'(jb_sj));
	end

	// ---------------- stage Q: squares (one 32x32 each), then sums
	logic              v_sq, v_ss;
	logic [HOR_W-1:0]  hor_sq, hor_ss;
	logic [63:0]       sq_sq [4];
	logic [63:0]       sp_ss, sqq_ss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
			v_ss <= 1'b0;
		end else begin
			v_sq <= v_sm;
			v_ss <= v_sq;
		end
	end
	always_ff @(posedge clk) begin
		hor_sq <= hor_sm;
		for (int k = 0; k < 4; k++) sq_sq[k] <= 64'(cm_sm[k]) * 64'(cm_sm[k]);
		hor_ss <= hor_sq;
		sp_ss  <= sq_sq[0] + sq_sq[1];
		sqq_ss <= sq_sq[2] + sq_sq[3];
	end

	// ---------------- square roots: one root bit a stage, both roots in parallel
	logic              rt_v  [RB+1];
	logic [HOR_W-1:0]  rt_h  [RB+1];
	logic [65:0]       rt_r  [RB+1][2];
	logic [63:0]       rt_n  [RB+1][2];
	logic [RB-1:0]     rt_q  [RB+1][2];

	always_comb begin
		rt_v[0] = v_ss;
		rt_h[0] = hor_ss;
		rt_n[0][0] = sp_ss;
		rt_n[0][1] = sqq_ss;
		for (int k = 0; k < 2; k++) begin
			rt_r[0][k] = '0;
			rt_q[0][k] = '0;
		end
	end

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v[i+1] <= 1'b0;
			else rt_v[i+1] <= rt_v[i];
		end
		always_ff @(posedge clk) begin
			logic [65:0] r, t;
			rt_h[i+1] <= rt_h[i];
			for (int k = 0; k < 2; k++) begin
				r = {rt_r[i][k][63:0], rt_n[i][k][63:62]};
				t = {32'd0, rt_q[i][k], 2'b01};
				if (r >= t) begin
					rt_r[i+1][k] <= r - t;
					rt_q[i+1][k] <= {rt_q[i][k][RB-2:0], 1'b1};
				end else begin
					rt_r[i+1][k] <= r;
					rt_q[i+1][k] <= {rt_q[i][k][RB-2:0], 1'b0};
				end
				rt_n[i+1][k] <= rt_n[i][k] << 2;
			end
		end
	end

	// ---------------- stage N: sigma, leading one and mantissa
	logic              v_sn, v_sz;
	logic [HOR_W-1:0]  hor_sn, hor_sz;
	logic [32:0]       s2_sz;
	logic [5:0]        msb_sn;
	logic [32:0]       man_sn;
	logic              zs_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sz <= 1'b0;
			v_sn <= 1'b0;
		end else begin
			v_sz <= rt_v[RB];
			v_sn <= v_sz;
		end
	end
	always_ff @(posedge clk) begin
		logic [5:0] ms;
		hor_sz <= rt_h[RB];
		s2_sz  <= 33'(rt_q[RB][0]) + 33'(rt_q[RB][1]);
		ms = '0;
		for (int b = 0; b < 33; b++) if (s2_sz[b]) ms = 6'(b);
		hor_sn <= hor_sz;
		msb_sn <= ms;
		zs_sn  <= (s2_sz == '0);
		man_sn <= (ms >= 6'd31) ? 33'(s2_sz >> (ms - 6'd31)) : 33'(s2_sz << (6'd31 - ms));
	end

	// ---------------- log2 fraction: one squaring a stage (33x33 into 33)
	logic              lg_v  [FB+1];
	logic [HOR_W-1:0]  lg_h  [FB+1];
	logic [5:0]        lg_e  [FB+1];
	logic              lg_z  [FB+1];
	logic [32:0]       lg_m  [FB+1];
	logic [FB-1:0]     lg_f  [FB+1];

	always_comb begin
		lg_v[0] = v_sn;
		lg_h[0] = hor_sn;
		lg_e[0] = msb_sn;
		lg_z[0] = zs_sn;
		lg_m[0] = man_sn;
		lg_f[0] = '0;
	end

	for (genvar i = 0; i < FB; i++) begin : g_log
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lg_v[i+1] <= 1'b0;
			else lg_v[i+1] <= lg_v[i];
		end
		always_ff @(posedge clk) begin
			logic [65:0] p;
			logic [34:0] m;
			p = 66'(lg_m[i]) * 66'(lg_m[i]);
			m = 35'(p >> 31);
			lg_h[i+1] <= lg_h[i];
			lg_e[i+1] <= lg_e[i];
			lg_z[i+1] <= lg_z[i];
			if (m[32] || m[33] || m[34]) begin
				lg_m[i+1] <= 33'(m >> 1);
				lg_f[i+1] <= {lg_f[i][FB-2:0], 1'b1};
			end else begin
				lg_m[i+1] <= 33'(m);
				lg_f[i+1] <= {lg_f[i][FB-2:0], 1'b0};
			end
		end
	end

	// ---------------- stage G: signed log2 magnitude
	logic              v_sg;
	logic [HOR_W-1:0]  hor_sg;
	logic              z_sg, neg_sg;
	logic [38:0]       lm_sg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sg <= 1'b0;
		else v_sg <= lg_v[FB];
	end
	always_ff @(posedge clk) begin
		logic signed [39:0] l2;
		l2 = $signed({{2{1'b0}}, lg_e[FB], 32'd0})
			- $signed(40'(64'(ftle_pkg::JAC_FRAC + 1) << 32))
			+ $signed({8'd0, lg_f[FB]});
		hor_sg <= lg_h[FB];
		z_sg   <= lg_z[FB];
		neg_sg <= l2[39];
		lm_sg  <= l2[39] ? 39'(-l2) : 39'(l2);
	end

	// ---------------- stage L: two partial products by ln2
	logic              v_sl, v_sk;
	logic [HOR_W-1:0]  hor_sl, hor_sk;
	logic              z_sl, neg_sl, z_sk, neg_sk;
	logic [38:0]       ph_sl;
	logic [63:0]       pl_sl;
	logic [LN_W-1:0]   ln_sk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sl <= 1'b0;
			v_sk <= 1'b0;
		end else begin
			v_sl <= v_sg;
			v_sk <= v_sl;
		end
	end
	always_ff @(posedge clk) begin
		hor_sl <= hor_sg;
		z_sl   <= z_sg;
		neg_sl <= neg_sg;
		ph_sl  <= 39'(64'(lm_sg[38:32]) * 64'(ftle_pkg::LN2_Q32));
		pl_sl  <= 64'(lm_sg[31:0]) * 64'(ftle_pkg::LN2_Q32);
		hor_sk <= hor_sl;
		z_sk   <= z_sl;
		neg_sk <= neg_sl;
		ln_sk  <= LN_W'(ph_sl) + LN_W'((pl_sl + 64'h8000_0000) >> 32);
	end

	// ---------------- rate divide: one quotient bit a stage
	logic              rd_v  [RQ+1];
	logic [HOR_W-1:0]  rd_h  [RQ+1];
	logic              rd_z  [RQ+1];
	logic              rd_s  [RQ+1];
	logic [DV_W:0]     rd_r  [RQ+1];
	logic [RQ-1:0]     rd_n  [RQ+1];
	logic [RQ-1:0]     rd_q  [RQ+1];

	always_comb begin
		logic [DV_W-1:0] dv;
		dv = {hor_sk, {SH{1'b0}}};
		rd_v[0] = v_sk;
		rd_h[0] = hor_sk;
		rd_z[0] = z_sk;
		rd_s[0] = neg_sk;
		rd_r[0] = '0;
		rd_n[0] = ln_sk + LN_W'(dv >> 1);
		rd_q[0] = '0;
	end

	for (genvar i = 0; i < RQ; i++) begin : g_rdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rd_v[i+1] <= 1'b0;
			else rd_v[i+1] <= rd_v[i];
		end
		always_ff @(posedge clk) begin
			logic [DV_W+1:0] r;
			logic [DV_W+1:0] d;
			d = (DV_W+2)'({rd_h[i], {SH{1'b0}}});
			r = {rd_r[i], rd_n[i][RQ-1]};
			rd_h[i+1] <= rd_h[i];
			rd_z[i+1] <= rd_z[i];
			rd_s[i+1] <= rd_s[i];
			rd_n[i+1] <= rd_n[i] << 1;
			if (r >= d && d != '0) begin
				rd_r[i+1] <= (DV_W+1)'(r - d);
				rd_q[i+1] <= {rd_q[i][RQ-2:0], 1'b1};
			end else begin
				rd_r[i+1] <= (DV_W+1)'(r);
				rd_q[i+1] <= {rd_q[i][RQ-2:0], 1'b0};
			end
		end
	end

	// ---------------- output stage: special cases, sign, saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= rd_v[RQ];
	end
	always_ff @(posedge clk) begin
		logic [RQ-1:0] q;
		q = rd_q[RQ];
		priority if (rd_h[RQ] == '0) begin
			lyapunov_rate <= '0;
			status        <= ftle_pkg::ST_ZERO_HOR;
		end else if (rd_z[RQ]) begin
			lyapunov_rate <= 32'sh8000_0000;
			status        <= ftle_pkg::ST_ZERO_STR;
		end else if (rd_s[RQ]) begin
			lyapunov_rate <= (q > RQ'(64'h8000_0000)) ? 32'sh8000_0000 : $signed(32'(-q));
			status        <= ftle_pkg::ST_NORMAL;
		end else begin
			lyapunov_rate <= (q > RQ'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(32'(q));
			status        <= ftle_pkg::ST_NORMAL;
		end
	end

	// ---------------- checks
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_zero_hor: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ftle_pkg::ST_ZERO_HOR |-> lyapunov_rate == 32'sd0)
		else $error("zero horizon with non-zero rate");
	a_zero_str: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ftle_pkg::ST_ZERO_STR |-> lyapunov_rate == 32'sh8000_0000)
		else $error("zero stretch not saturated");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3)
		else $error("bad status");
endmodule

// ===== tb/ftle_from_neighbor_spread_core_tb.sv =====
// Self-checking testbench for the FTLE neighbour-spread core.
`timescale 1ns / 1ps
module ftle_from_neighbor_spread_core_tb;

	typedef struct {
		logic signed [31:0] rate;
		logic [1:0]         st;
	} ftle_res_t;

	class ftle_scoreboard;
		ftle_res_t pending[$];
		int errors;
		int checked;

		task report_err(string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		function void note(ftle_res_t r);
			pending.push_back(r);
		endfunction

		task check(logic signed [31:0] rate, logic [1:0] st);
			ftle_res_t e;
			checked++;
			if (pending.size() == 0) begin
				report_err($sformatf("unexpected beat rate=%h status=%0d", rate, st));
				return;
			end
			e = pending.pop_front();
			if (rate !== e.rate)
				report_err($sformatf("rate got %h want %h", rate, e.rate));
			if (st !== e.st)
				report_err($sformatf("status got %0d want %0d", st, e.st));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [39:0] east_lon = 0, east_lat = 0, north_lon = 0, north_lat = 0;
	logic signed [39:0] west_lon = 0, west_lat = 0, south_lon = 0, south_lat = 0;
	logic [38:0] span_lon = 1, span_lat = 1;
	logic [11:0] horizon_days = 0;
	logic done;
	logic signed [31:0] lyapunov_rate;
	logic [1:0] status;

	ftle_scoreboard sb;
	int watchdog = 0;
	int sent = 0;
	int n_zero_hor = 0, n_zero_str = 0;

	always #4 clk = ~clk;

	ftle_from_neighbor_spread_core u_top (.*);

	// per-entry Jacobian term, Q.20 signed, rounded half up and saturated
	function automatic longint jac_term(longint diff, logic [38:0] span);
		logic [127:0] m, q, sp;
		sp = (span == 0) ? 1 : span;
		m = (diff < 0) ? -diff : diff;
		q = ((m << ftle_pkg::JAC_FRAC) + sp / 2) / sp;
		if (q > ftle_pkg::JAC_MAX) q = ftle_pkg::JAC_MAX;
		return (diff < 0) ? -longint'(q[40:0]) : longint'(q[40:0]);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] hyp_root(longint x, longint y);
		logic [63:0] ux, uy;
		ux = (x < 0) ? -x : x;
		uy = (y < 0) ? -y : y;
		return root_floor(ux * ux + uy * uy);
	endfunction

	function automatic ftle_res_t predict_ftle(
		logic signed [39:0] el, ela, nl, nla, wl, wla, sl, sla,
		logic [38:0] spl, spa, logic [11:0] hor);
		ftle_res_t r;
		longint a, b, c, d, l2;
		logic [63:0] p, q, s2, m, frac, lm, lnmag, dv, rm;
		int msb;
		if (hor == 0) begin
			r.rate = 0; r.st = ftle_pkg::ST_ZERO_HOR;
			return r;
		end
		a = jac_term(longint'(el) - longint'(wl), spl);
		b = jac_term(longint'(nl) - longint'(sl), spa);
		c = jac_term(longint'(ela) - longint'(wla), spl);
		d = jac_term(longint'(nla) - longint'(sla), spa);
		p = hyp_root(a + d, c - b);
		q = hyp_root(a - d, c + b);
		s2 = p + q;
		if (s2 == 0) begin
			r.rate = 32'h80000000; r.st = ftle_pkg::ST_ZERO_STR;
			return r;
		end
		msb = 0;
		while (msb < 63 && (s2 >> (msb + 1)) != 0) msb++;
		m = (msb >= 31) ? s2 >> (msb - 31) : s2 << (31 - msb);
		frac = 0;
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			frac <<= 1;
			if (m >= 64'h1_0000_0000) begin
				frac |= 1;
				m >>= 1;
			end
		end
		l2 = longint'(msb - (ftle_pkg::JAC_FRAC + 1)) * 64'sh1_0000_0000 + longint'(frac);
		lm = (l2 < 0) ? -l2 : l2;
		lnmag = (lm >> 32) * ftle_pkg::LN2_Q32
			+ (((lm & 64'hFFFF_FFFF) * ftle_pkg::LN2_Q32 + (64'd1 << 31)) >> 32);
		dv = 64'(hor) << (32 - ftle_pkg::FRAC_BITS);
		rm = (lnmag + dv / 2) / dv;
		if (l2 < 0) begin
			if (rm > (64'd1 << 31)) rm = 64'd1 << 31;
			r.rate = 32'((64'd1 << 32) - rm);
		end else begin
			if (rm > 64'h7FFF_FFFF) rm = 64'h7FFF_FFFF;
			r.rate = rm[31:0];
		end
		r.st = ftle_pkg::ST_NORMAL;
		return r;
	endfunction

	function automatic logic [39:0] rand40();
		return 40'({$urandom_range(255, 0), $urandom()});
	endfunction

	// raise start and hold it until acceptance; it stays high until idle_gap or the caller clears it
	task automatic send_beat(logic signed [39:0] el, ela, nl, nla, wl, wla, sl, sla,
		logic [38:0] spl, spa, logic [11:0] hor);
		start <= 1;
		east_lon <= el; east_lat <= ela; north_lon <= nl; north_lat <= nla;
		west_lon <= wl; west_lat <= wla; south_lon <= sl; south_lat <= sla;
		span_lon <= spl; span_lat <= spa; horizon_days <= hor;
		do @(posedge clk); while (busy);
		sb.note(predict_ftle(el, ela, nl, nla, wl, wla, sl, sla, spl, spa, hor));
		sent++;
		if (hor == 0) n_zero_hor++;
	endtask

	task automatic idle_gap(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	// mostly a near tracer (neighbours spread around a common centre with random distortion), else equal or random points
	task automatic send_random();
		logic signed [39:0] cx, cy, k;
		logic [38:0] sx, sy;
		logic [11:0] hor;
		int mode;
		mode = $urandom_range(9, 0);
		hor = ($urandom_range(19, 0) == 0) ? 0 :
			($urandom_range(3, 0) == 0) ? 12'($urandom()) : 12'($urandom_range(60, 1));
		if (mode < 6) begin
			cx = 40'(longint'($signed($urandom())) <<< 4);
			cy = 40'(longint'($signed($urandom())) <<< 4);
			sx = 39'($urandom_range(1 << 24, 1 << 14));
			sy = 39'($urandom_range(1 << 24, 1 << 14));
			k = 40'($urandom_range(8, 0));
			send_beat(cx + ((sx * k) >> 2) + $signed(40'($signed($urandom_range(4095,0)) - 2048)),
				cy + $signed(40'($urandom_range(1 << 20, 0))),
				cx + $signed(40'($urandom_range(1 << 20, 0))),
				cy + ((sy * k) >> 2),
				cx - ((sx * k) >> 2), cy - $signed(40'($urandom_range(1 << 18, 0))),
				cx, cy - ((sy * k) >> 2), sx, sy, hor);
		end else if (mode < 8) begin
			cx = rand40();
			send_beat(cx, cx, cx, cx, cx, cx, cx, cx,
				39'($urandom_range(3, 0)), 39'($urandom()), hor);
		end else
			send_beat(rand40(), rand40(), rand40(), rand40(), rand40(), rand40(),
				rand40(), rand40(), 39'({$urandom_range(127, 0), $urandom()}),
				39'({$urandom_range(127, 0), $urandom()}), hor);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check(lyapunov_rate, status);
			if (status == ftle_pkg::ST_ZERO_STR) n_zero_str++;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog > 20000) begin
			$display("Timeout: no beat for %0d cycles", watchdog);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	localparam logic signed [39:0] PMAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] PMIN = 40'sh80_0000_0000;
	localparam logic [38:0] SMAX = 39'h7F_FFFF_FFFF;

	initial begin
		int burst;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed corners
		send_beat(1 << 24, 0, 0, 1 << 24, -(1 << 24), 0, 0, -(1 << 24), 2 << 24, 2 << 24, 1);
		send_beat(PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, 1, 1, 1);
		send_beat(PMIN, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, 1, 1, 12'hFFF);
		send_beat(PMAX, PMIN, PMIN, PMAX, PMIN, PMAX, PMAX, PMIN, SMAX, SMAX, 12'hFFF);
		send_beat(5, 5, 5, 5, 5, 5, 5, 5, 1 << 24, 1 << 24, 3);
		send_beat(PMAX, PMIN, 0, 1, PMIN, PMAX, 1, 0, 0, 0, 7);
		send_beat(1, 0, 0, 1, 0, 0, 0, 0, SMAX, SMAX, 1);
		send_beat(PMAX, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
		send_beat(3 << 24, 1 << 24, -(1 << 24), 1 << 22, -(3 << 24), -(1 << 24), 1 << 24,
			-(1 << 22), 2 << 24, 2 << 24, 20);
		send_beat(1 << 20, 0, 0, 1 << 20, -(1 << 20), 0, 0, -(1 << 20), 2 << 24, 2 << 24, 1);
		send_beat(1 << 20, 0, 0, 1 << 20, -(1 << 20), 0, 0, -(1 << 20), 2 << 24, 2 << 24,
			12'hFFF);
		send_beat(0, 0, 0, 0, 0, 0, 0, 0, SMAX, 1, 12'h800);
		idle_gap(1);
		// wait for the pipe to drain completely once
		while (sb.pending.size() != 0) @(posedge clk);
		for (int i = 0; i < 1850; ) begin
			burst = $urandom_range(40, 1);
			for (int j = 0; j < burst && i < 1850; j++, i++)
				send_random();
			if ($urandom_range(3, 0) != 0)
				idle_gap($urandom_range(6, 1));
			if (i > 900 && i < 950) begin
				start <= 0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d items (%0d zero horizon), checked %0d results, %0d zero stretch",
			sent, n_zero_hor, sb.checked, n_zero_str);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/ftle_pkg.sv
sv/ftle_from_neighbor_spread_core.sv
tb/ftle_from_neighbor_spread_core_tb.sv
